// ===== sv/pmes_pkg.sv =====
`timescale 1ns / 1ps

package pmes_pkg;

  localparam int EvW      = 3;
  localparam int FuncW    = 2;
  localparam int SecW     = 16;
  localparam int CfgDataW = 32;
  localparam int CfgAddrW = 4;

  typedef logic [EvW-1:0]   event_t;
  typedef logic [FuncW-1:0] func_t;
  typedef logic [SecW-1:0]  sec_t;

  localparam event_t EV_POWER_UP = 3'd0;
  localparam event_t EV_WAIT     = 3'd1;
  localparam event_t EV_PREPARE  = 3'd2;
  localparam event_t EV_ENTER    = 3'd3;
  localparam event_t EV_EXT1     = 3'd4;
  localparam event_t EV_EXT2     = 3'd5;
  localparam event_t EV_RTC      = 3'd6;
  localparam event_t EV_EXIT     = 3'd7;

  localparam func_t FUNC_REQUEST = 2'd0;
  localparam func_t FUNC_TICK    = 2'd1;
  localparam func_t FUNC_SLEEP   = 2'd2;
  localparam func_t FUNC_POLL    = 2'd3;

  localparam logic [1:0] REG_KEEP_AWAKE = 2'd0;
  localparam logic [1:0] REG_WAIT_HOLD  = 2'd1;
  localparam logic [1:0] REG_EXT_HOLD   = 2'd2;

  localparam sec_t WAIT_HOLD_RST = 16'd300;
  localparam sec_t EXT_HOLD_RST  = 16'd3;
  localparam sec_t SEC_MAX       = 16'hFFFF;

  typedef struct packed {
    logic keep_awake;
    sec_t wait_hold_seconds;
    sec_t ext_wake_hold_seconds;
  } cfg_t;

  // bit p set when event p may precede requested event
  function automatic logic [7:0] legal_from(event_t req);
    logic [7:0] m;
    case (req)
      EV_POWER_UP: m = 8'hFF;
      EV_WAIT:     m = (8'd1 << EV_POWER_UP) | (8'd1 << EV_EXIT);
      EV_PREPARE:  m = 8'd1 << EV_WAIT;
      EV_ENTER:    m = (8'd1 << EV_PREPARE) | (8'd1 << EV_EXT1) |
                       (8'd1 << EV_EXT2) | (8'd1 << EV_RTC);
      EV_EXT1:     m = 8'd1 << EV_ENTER;
      EV_EXT2:     m = 8'd1 << EV_ENTER;
      EV_RTC:      m = 8'd1 << EV_ENTER;
      EV_EXIT:     m = (8'd1 << EV_EXT1) | (8'd1 << EV_EXT2) | (8'd1 << EV_RTC);
      default:     m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/pmes_in_if.sv =====
`timescale 1ns / 1ps

interface pmes_in_if;
  logic                   valid;
  logic                   ready;
  pmes_pkg::func_t        func;
  pmes_pkg::event_t       requested_event;

  modport source (output valid, output func, output requested_event, input ready);
  modport sink (input valid, input func, input requested_event, output ready);
endinterface

// ===== sv/pmes_out_if.sv =====
`timescale 1ns / 1ps

interface pmes_out_if;
  logic             valid;
  logic             ready;
  logic             accepted;
  pmes_pkg::event_t current_event;
  logic             hold_expired;
  logic             go_low_power;

  modport source (output valid, output accepted, output current_event,
                  output hold_expired, output go_low_power, input ready);
  modport sink (input valid, input accepted, input current_event,
                input hold_expired, input go_low_power, output ready);
endinterface

// ===== sv/power_mode_event_sequencer.sv =====
`timescale 1ns / 1ps

// Power mode event sequencer.
// in_ch carries one transaction per command: func selects an event request,
// a one-second tick, a sleep request or a low-power poll; requested_event is
// used by requests only. out_ch returns exactly one transaction per input with
// the accept flag, the current event, the hold-expired flag and the poll answer.
// A result is registered: its input passes the input register, then the
// sequencer logic into the result register.
// Throughput: one transaction per cycle while out_ch does not stall; the single
// update of the event, seconds counter and hold limit per cycle sets that figure.
// Reset (rst_n low, synchronous) empties both registers, sets the power-up
// event with zero count, zero limit and no pending sleep, and loads the
// registers with keep_awake 0, wait hold 300 and external wake hold 3.
// When out_ch stalls, one more transaction is taken into the input register,
// then in_ch.ready drops until the result is taken.
// APB: keep_awake at 0x0, wait hold at 0x4, external wake hold at 0x8;
// write only while no transaction is in flight.

module power_mode_event_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  pmes_in_if.sink                       in_ch,
  pmes_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pmes_pkg::CfgAddrW-1:0] paddr,
  input  logic [pmes_pkg::CfgDataW-1:0] pwdata,
  output logic [pmes_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);

  pmes_pkg::cfg_t cfg;

  pmes_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pmes_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  a_accept_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.accepted |-> !out_ch.hold_expired)
    else $error("accepted event reported an expired hold");

  a_free_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with an empty result register");

  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");

  a_powerup_always_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.accepted && out_ch.current_event == pmes_pkg::EV_POWER_UP
    |-> !out_ch.go_low_power)
    else $error("request reported a low power answer");

endmodule

// ===== sv/pmes_cfg.sv =====
`timescale 1ns / 1ps

module pmes_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pmes_pkg::CfgAddrW-1:0]     paddr,
  input  logic [pmes_pkg::CfgDataW-1:0]     pwdata,
  output logic [pmes_pkg::CfgDataW-1:0]     prdata,
  output logic                              pready,
  output pmes_pkg::cfg_t                    cfg
);

  pmes_pkg::cfg_t cfg_r;
  pmes_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        pmes_pkg::REG_KEEP_AWAKE: cfg_nxt.keep_awake = pwdata[0];
        pmes_pkg::REG_WAIT_HOLD:  cfg_nxt.wait_hold_seconds = pwdata[15:0];
        pmes_pkg::REG_EXT_HOLD:   cfg_nxt.ext_wake_hold_seconds = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.keep_awake            <= 1'b0;
      cfg_r.wait_hold_seconds     <= pmes_pkg::WAIT_HOLD_RST;
      cfg_r.ext_wake_hold_seconds <= pmes_pkg::EXT_HOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      pmes_pkg::REG_KEEP_AWAKE: prdata = {31'd0, cfg_r.keep_awake};
      pmes_pkg::REG_WAIT_HOLD:  prdata = {16'd0, cfg_r.wait_hold_seconds};
      pmes_pkg::REG_EXT_HOLD:   prdata = {16'd0, cfg_r.ext_wake_hold_seconds};
      default:                  prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/pmes_core.sv =====
`timescale 1ns / 1ps

module pmes_core (
  input  logic           clk,
  input  logic           rst_n,
  input  pmes_pkg::cfg_t cfg,
  pmes_in_if.sink        in_ch,
  pmes_out_if.source     out_ch
);

  // input register
  logic               in_vld_r;
  pmes_pkg::func_t    func_r;
  pmes_pkg::event_t   req_r;
  // sequencer state
  pmes_pkg::event_t   present_r, present_nxt;
  pmes_pkg::sec_t     elapsed_r, elapsed_nxt;
  pmes_pkg::sec_t     hold_r, hold_nxt;
  logic               sleep_pend_r, sleep_pend_nxt;
  // result register
  logic               out_vld_r;
  logic               acc_r, acc_nxt;
  pmes_pkg::event_t   cur_r;
  logic               exp_r, exp_nxt;
  logic               go_r, go_nxt;

  logic               advance;
  logic               do_item;
  logic [7:0]         legal;

  assign advance     = !out_vld_r || out_ch.ready;
  assign in_ch.ready = !in_vld_r || advance;
  assign do_item     = in_vld_r && advance;
  assign legal       = pmes_pkg::legal_from(req_r);

  always_comb begin
    present_nxt    = present_r;
    elapsed_nxt    = elapsed_r;
    hold_nxt       = hold_r;
    sleep_pend_nxt = sleep_pend_r;
    acc_nxt        = 1'b0;
    go_nxt         = 1'b0;
    case (func_r)
      pmes_pkg::FUNC_REQUEST: begin
        if (legal[present_r]) begin
          acc_nxt     = 1'b1;
          present_nxt = req_r;
          elapsed_nxt = '0;
          if (req_r == pmes_pkg::EV_WAIT) begin
            hold_nxt = cfg.wait_hold_seconds;
          end else if (req_r == pmes_pkg::EV_EXT1 || req_r == pmes_pkg::EV_EXT2) begin
            hold_nxt = cfg.ext_wake_hold_seconds;
          end else begin
            hold_nxt = '0;
          end
        end
      end
      pmes_pkg::FUNC_TICK: begin
        if (elapsed_r != pmes_pkg::SEC_MAX) begin
          elapsed_nxt = elapsed_r + 16'd1;
        end
      end
      pmes_pkg::FUNC_SLEEP: begin
        sleep_pend_nxt = 1'b1;
      end
      pmes_pkg::FUNC_POLL: begin
        if (sleep_pend_r) begin
          sleep_pend_nxt = 1'b0;
          go_nxt         = 1'b1;
        end else if ((elapsed_r > hold_r) && !cfg.keep_awake) begin
          go_nxt = 1'b1;
        end
      end
      default: ;
    endcase
    exp_nxt = elapsed_nxt > hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      present_r    <= pmes_pkg::EV_POWER_UP;
      elapsed_r    <= '0;
      hold_r       <= '0;
      sleep_pend_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
      if (do_item) begin
        present_r    <= present_nxt;
        elapsed_r    <= elapsed_nxt;
        hold_r       <= hold_nxt;
        sleep_pend_r <= sleep_pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_r <= in_ch.func;
      req_r  <= in_ch.requested_event;
    end
    if (do_item) begin
      acc_r <= acc_nxt;
      cur_r <= present_nxt;
      exp_r <= exp_nxt;
      go_r  <= go_nxt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.accepted      = acc_r;
  assign out_ch.current_event = cur_r;
  assign out_ch.hold_expired  = exp_r;
  assign out_ch.go_low_power  = go_r;

endmodule

// ===== tb/tb_power_mode_event_sequencer.sv =====
`timescale 1ns / 1ps

module tb_power_mode_event_sequencer;

  localparam logic [1:0] REG_NONE = 2'd3;  // unmapped slot, writes are dropped

  typedef struct packed {
    logic             accepted;
    pmes_pkg::event_t current_ev;
    logic             expired;
    logic             go;
  } seq_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pmes_in_if  in_ch ();
  pmes_out_if out_ch ();

  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [pmes_pkg::CfgAddrW-1:0] paddr = '0;
  logic [pmes_pkg::CfgDataW-1:0] pwdata = '0;
  logic [pmes_pkg::CfgDataW-1:0] prdata;
  logic                          pready;

  power_mode_event_sequencer DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // sequencer state as predicted
  pmes_pkg::event_t m_event   = pmes_pkg::EV_POWER_UP;
  pmes_pkg::sec_t   m_elapsed = '0;
  pmes_pkg::sec_t   m_limit   = '0;
  logic             m_sleep   = 1'b0;
  // register copies
  logic             c_force     = 1'b0;
  pmes_pkg::sec_t   c_wait_hold = pmes_pkg::WAIT_HOLD_RST;
  pmes_pkg::sec_t   c_ext_hold  = pmes_pkg::EXT_HOLD_RST;

  seq_result_t expected_results[$];

  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_taken = 0;
  int n_go = 0;
  bit idle_on = 1'b1;
  int hold_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = pmes_pkg::FUNC_REQUEST;
    in_ch.requested_event = pmes_pkg::EV_POWER_UP;
  end

  function automatic bit may_follow(pmes_pkg::event_t req, pmes_pkg::event_t cur);
    case (req)
      pmes_pkg::EV_POWER_UP: return 1'b1;
      pmes_pkg::EV_WAIT:
        return cur == pmes_pkg::EV_POWER_UP || cur == pmes_pkg::EV_EXIT;
      pmes_pkg::EV_PREPARE: return cur == pmes_pkg::EV_WAIT;
      pmes_pkg::EV_ENTER:
        return cur == pmes_pkg::EV_PREPARE || cur == pmes_pkg::EV_EXT1 ||
               cur == pmes_pkg::EV_EXT2 || cur == pmes_pkg::EV_RTC;
      pmes_pkg::EV_EXT1, pmes_pkg::EV_EXT2, pmes_pkg::EV_RTC:
        return cur == pmes_pkg::EV_ENTER;
      default:
        return cur == pmes_pkg::EV_EXT1 || cur == pmes_pkg::EV_EXT2 ||
               cur == pmes_pkg::EV_RTC;
    endcase
  endfunction

  task automatic predict_sequencer(pmes_pkg::func_t f, pmes_pkg::event_t ev);
    seq_result_t r;
    r = '0;
    case (f)
      pmes_pkg::FUNC_REQUEST: begin
        if (may_follow(ev, m_event)) begin
          m_event = ev;
          m_elapsed = '0;
          if (ev == pmes_pkg::EV_WAIT) m_limit = c_wait_hold;
          else if (ev == pmes_pkg::EV_EXT1 || ev == pmes_pkg::EV_EXT2) m_limit = c_ext_hold;
          else m_limit = '0;
          r.accepted = 1'b1;
        end
      end
      pmes_pkg::FUNC_TICK: begin
        if (m_elapsed != pmes_pkg::SEC_MAX) m_elapsed = m_elapsed + 1'b1;
      end
      pmes_pkg::FUNC_SLEEP: begin
        m_sleep = 1'b1;
      end
      default: begin
        if (m_sleep) begin
          m_sleep = 1'b0;
          r.go = 1'b1;
        end else if (m_elapsed > m_limit && !c_force) begin
          r.go = 1'b1;
        end
      end
    endcase
    r.current_ev = m_event;
    r.expired = m_elapsed > m_limit;
    expected_results.push_back(r);
  endtask

  // called at a falling edge; leaves valid high on return
  task automatic send_item(pmes_pkg::func_t f, pmes_pkg::event_t ev);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.func = f;
    in_ch.requested_event = ev;
    do @(posedge clk); while (!in_ch.ready);
    predict_sequencer(f, ev);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [pmes_pkg::CfgDataW-1:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      pmes_pkg::REG_KEEP_AWAKE: c_force = val[0];
      pmes_pkg::REG_WAIT_HOLD:  c_wait_hold = val[pmes_pkg::SecW-1:0];
      pmes_pkg::REG_EXT_HOLD:   c_ext_hold = val[pmes_pkg::SecW-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_config(logic fw, pmes_pkg::sec_t wait_hold, pmes_pkg::sec_t ext_hold,
                            bit junk);
    logic [pmes_pkg::CfgDataW-1:0] hi;
    hi = junk ? $urandom : '0;
    write_reg(pmes_pkg::REG_KEEP_AWAKE, {hi[pmes_pkg::CfgDataW-1:1], fw});
    write_reg(pmes_pkg::REG_WAIT_HOLD, {hi[pmes_pkg::CfgDataW-1:pmes_pkg::SecW], wait_hold});
    write_reg(pmes_pkg::REG_EXT_HOLD, {hi[pmes_pkg::CfgDataW-1:pmes_pkg::SecW], ext_hold});
  endtask

  function automatic pmes_pkg::event_t any_event();
    return pmes_pkg::event_t'($urandom_range(0, 7));
  endfunction

  task automatic send_random_item();
    int r;
    int tries;
    pmes_pkg::event_t ev;
    r = $urandom_range(0, 99);
    ev = any_event();
    if (r < 40) begin
      if ($urandom_range(0, 3) != 0) begin
        tries = 0;
        while (!may_follow(ev, m_event) ||
               (ev == pmes_pkg::EV_POWER_UP && tries < 6)) begin
          ev = any_event();
          tries++;
        end
      end
      send_item(pmes_pkg::FUNC_REQUEST, ev);
    end else if (r < 75) begin
      send_item(pmes_pkg::FUNC_TICK, ev);
    end else if (r < 85) begin
      send_item(pmes_pkg::FUNC_SLEEP, ev);
    end else begin
      send_item(pmes_pkg::FUNC_POLL, ev);
    end
  endtask

  // result side: random stalls, plus an optional long hold-off
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    seq_result_t got;
    seq_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.accepted, out_ch.current_event, out_ch.hold_expired,
             out_ch.go_low_power};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transaction: acc=%0d ev=%0d exp=%0d go=%0d",
                 $time, got.accepted, got.current_ev, got.expired, got.go);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        n_checked++;
        if (exp_r.accepted) n_taken++;
        if (exp_r.go) n_go++;
        if (got !== exp_r) begin
          $display("%0t: mismatch acc/ev/exp/go: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                   $time, exp_r.accepted, exp_r.current_ev, exp_r.expired, exp_r.go,
                   got.accepted, got.current_ev, got.expired, got.go);
          errors++;
        end
      end
    end
  end

  task automatic test_transitions();
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_ENTER);
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_WAIT);
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_WAIT);
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_PREPARE);
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_ENTER);
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_EXT1);
    repeat (4) send_item(pmes_pkg::FUNC_TICK, any_event());
    send_item(pmes_pkg::FUNC_POLL, any_event());
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_ENTER);
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_EXT2);
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_EXIT);
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_WAIT);
    send_item(pmes_pkg::FUNC_SLEEP, any_event());
    send_item(pmes_pkg::FUNC_SLEEP, any_event());
    send_item(pmes_pkg::FUNC_POLL, any_event());
    send_item(pmes_pkg::FUNC_POLL, any_event());
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_PREPARE);
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_ENTER);
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_RTC);
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_EXIT);
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_POWER_UP);
    send_item(pmes_pkg::FUNC_TICK, any_event());
    send_item(pmes_pkg::FUNC_POLL, any_event());
    settle();
  endtask

  task automatic test_force_and_sleep();
    set_config(1'b1, pmes_pkg::SEC_MAX, '0, 1'b0);
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_POWER_UP);
    send_item(pmes_pkg::FUNC_TICK, any_event());
    send_item(pmes_pkg::FUNC_POLL, any_event());
    send_item(pmes_pkg::FUNC_SLEEP, any_event());
    send_item(pmes_pkg::FUNC_POLL, any_event());
    send_item(pmes_pkg::FUNC_POLL, any_event());
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_WAIT);
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_PREPARE);
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_ENTER);
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_EXT1);
    send_item(pmes_pkg::FUNC_TICK, any_event());
    send_item(pmes_pkg::FUNC_POLL, any_event());
    settle();
    write_reg(pmes_pkg::REG_KEEP_AWAKE, '0);
    send_item(pmes_pkg::FUNC_POLL, any_event());
    settle();
  endtask

  task automatic test_hold_expiry();
    set_config(1'b0, 16'd5, pmes_pkg::EXT_HOLD_RST, 1'b0);
    idle_on = 1'b0;
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_POWER_UP);
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_WAIT);
    repeat (5) send_item(pmes_pkg::FUNC_TICK, any_event());
    send_item(pmes_pkg::FUNC_POLL, any_event());
    repeat (2) send_item(pmes_pkg::FUNC_TICK, any_event());
    send_item(pmes_pkg::FUNC_POLL, any_event());
    send_item(pmes_pkg::FUNC_REQUEST, pmes_pkg::EV_POWER_UP);
    repeat (3) send_item(pmes_pkg::FUNC_TICK, any_event());
    send_item(pmes_pkg::FUNC_POLL, any_event());
    settle();
    idle_on = 1'b1;
  endtask

  task automatic test_output_stall();
    set_config(1'b0, 16'd4, 16'd2, 1'b0);
    hold_cycles = 80;
    repeat (40) send_random_item();
    settle();
  endtask

  task automatic random_phase(logic fw, pmes_pkg::sec_t wait_hold,
                              pmes_pkg::sec_t ext_hold, bit junk, bit idle, int n);
    set_config(fw, wait_hold, ext_hold, junk);
    idle_on = idle;
    repeat (n) send_random_item();
    settle();
    idle_on = 1'b1;
  endtask

  task automatic test_random_configs();
    random_phase(1'b0, pmes_pkg::WAIT_HOLD_RST, pmes_pkg::EXT_HOLD_RST, 1'b0, 1'b1, 250);
    random_phase(1'b1, '0, '0, 1'b0, 1'b1, 250);
    random_phase(1'b0, 16'd2, 16'd1, 1'b0, 1'b0, 250);
    write_reg(REG_NONE, $urandom);
    random_phase(1'b0, pmes_pkg::sec_t'($urandom_range(0, 20)),
                 pmes_pkg::sec_t'($urandom_range(0, 8)), 1'b1, 1'b1, 250);
    random_phase(1'b1, pmes_pkg::SEC_MAX, pmes_pkg::SEC_MAX, 1'b1, 1'b1, 250);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_transitions();
    test_force_and_sleep();
    test_hold_expiry();
    test_output_stall();
    test_random_configs();
    repeat (10) @(posedge clk);
    $display("Checked %0d results of %0d input transactions;", n_checked, n_sent);
    $display("%0d requests taken, %0d low-power answers; covered illegal requests,",
             n_taken, n_go);
    $display("forced work, hold expiry, hold extremes and a long output stall.");
    if (errors == 0) begin
      $display("tb_power_mode_event_sequencer: PASS");
    end else begin
      $display("tb_power_mode_event_sequencer: FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("tb_power_mode_event_sequencer: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
sv/pmes_pkg.sv
sv/pmes_in_if.sv
sv/pmes_out_if.sv
sv/pmes_cfg.sv
sv/pmes_core.sv
sv/power_mode_event_sequencer.sv
tb/tb_power_mode_event_sequencer.sv
